// ----- hdl/qslerp_pkg.sv -----
`default_nettype none

package qslerp_pkg;

    localparam int CB_DEF       = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int SQ_NW        = 61;
    localparam int SN_W         = 31;
    localparam int CW           = 34;
    localparam int DIV_QB       = 49;
    localparam int WT_W         = 35;

    localparam logic [15:0]   THR_RESET   = 16'd33;
    localparam logic [15:0]   T_ONE       = 16'h8000;
    localparam logic          REG_THR_IDX = 1'b0;
    localparam logic [CW-1:0] CORDIC_GAIN = 34'd652032874;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic [15:0] t_q15;

    function automatic logic [29:0] arc_at(input int i);
        case (i)
            0:  arc_at = 30'd843314857;
            1:  arc_at = 30'd497837829;
            2:  arc_at = 30'd263043837;
            3:  arc_at = 30'd133525159;
            4:  arc_at = 30'd67021687;
            5:  arc_at = 30'd33543516;
            6:  arc_at = 30'd16775851;
            7:  arc_at = 30'd8388437;
            8:  arc_at = 30'd4194283;
            9:  arc_at = 30'd2097149;
            10: arc_at = 30'd1048576;
            11: arc_at = 30'd524288;
            12: arc_at = 30'd262144;
            13: arc_at = 30'd131072;
            14: arc_at = 30'd65536;
            15: arc_at = 30'd32768;
            16: arc_at = 30'd16384;
            17: arc_at = 30'd8192;
            18: arc_at = 30'd4096;
            19: arc_at = 30'd2048;
            20: arc_at = 30'd1024;
            21: arc_at = 30'd512;
            22: arc_at = 30'd256;
            23: arc_at = 30'd128;
            24: arc_at = 30'd64;
            25: arc_at = 30'd32;
            26: arc_at = 30'd16;
            27: arc_at = 30'd8;
            28: arc_at = 30'd4;
            29: arc_at = 30'd2;
            default: arc_at = 30'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- hdl/quaternion_slerp.sv -----
// channel  dir  handshake           payload
// in       in   i_valid / o_stall   i_start_*, i_end_*, i_blend_time
// out      out  o_valid / i_stall   o_out_*
// cfg      in   apb, pready = 1     near_parallel_threshold at byte 0x0
//
// one item accepted per cycle while o_stall is low
// an item runs through the 31-stage square root, two 30-stage cordic chains and a 51-stage divider
// a held output (o_valid with i_stall) freezes every stage and raises o_stall
// i_rst_n is synchronous: it empties the pipeline and sets the threshold to 33
`default_nettype none

module quaternion_slerp import qslerp_pkg::*; #(
    parameter int COMPONENT_BITS = CB_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [COMPONENT_BITS-1:0] i_start_w,
    input  logic signed [COMPONENT_BITS-1:0] i_start_x,
    input  logic signed [COMPONENT_BITS-1:0] i_start_y,
    input  logic signed [COMPONENT_BITS-1:0] i_start_z,
    input  logic signed [COMPONENT_BITS-1:0] i_end_w,
    input  logic signed [COMPONENT_BITS-1:0] i_end_x,
    input  logic signed [COMPONENT_BITS-1:0] i_end_y,
    input  logic signed [COMPONENT_BITS-1:0] i_end_z,
    input  logic [15:0]                      i_blend_time,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [COMPONENT_BITS-1:0] o_out_w,
    output logic signed [COMPONENT_BITS-1:0] o_out_x,
    output logic signed [COMPONENT_BITS-1:0] o_out_y,
    output logic signed [COMPONENT_BITS-1:0] o_out_z,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int CB     = COMPONENT_BITS;
    localparam int SW     = (CB > 31) ? 31 : CB;
    localparam int UP     = (CB > 31) ? 0 : 31 - CB;
    localparam int RS     = (CB > 31) ? 29 : 30;
    localparam int PW     = 2 * SW;
    localparam int SUMW   = PW + 2;
    localparam int MW     = CW + 17;
    localparam int PRW    = WT_W + SW;
    localparam int ACW    = PRW + 1;
    localparam int L_SQ   = SQRT_STEPS;
    localparam int L_AT   = CORDIC_STEPS;
    localparam int L_SIN  = CORDIC_STEPS;
    localparam int L_DIV  = DIV_QB + 2;
    localparam int N_HEAD = 6;
    localparam int D_SIDE = L_SQ + L_AT + 1 + L_SIN + L_DIV;
    localparam int NTOT   = N_HEAD + D_SIDE + 3;
    localparam int SIDEW  = 8 * SW + 18;

    localparam logic signed [ACW-1:0] SAT_HI = ACW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [ACW-1:0] SAT_LO = -SAT_HI - ACW'(1);
    localparam logic signed [ACW-1:0] RND    = ACW'(64'sd1 <<< (RS - 1));

    logic            w_en;
    logic [NTOT-1:0] r_vld;
    logic [15:0]     r_thr;
    logic            w_wr;

    logic signed [CB-1:0] w_si [4];
    logic signed [CB-1:0] w_ei [4];

    logic signed [SW-1:0]   r1_s [4];
    logic signed [SW-1:0]   r1_e [4];
    t_q15                   r1_tt;
    logic signed [PW-1:0]   r2_p [4];
    logic signed [SW-1:0]   r2_s [4];
    logic signed [SW-1:0]   r2_e [4];
    t_q15                   r2_tt;
    logic signed [SUMW-1:0] r3_sum;
    logic signed [SW-1:0]   r3_s [4];
    logic signed [SW-1:0]   r3_e [4];
    t_q15                   r3_tt;
    logic [CW-1:0]          r4_cos;
    logic                   r4_neg;
    logic signed [SW-1:0]   r4_s [4];
    logic signed [SW-1:0]   r4_e [4];
    t_q15                   r4_tt;
    logic                   r5_trig;
    logic [59:0]            r5_sq;
    logic [29:0]            r5_cos30;
    logic                   r5_neg;
    logic signed [SW-1:0]   r5_s [4];
    logic signed [SW-1:0]   r5_e [4];
    t_q15                   r5_tt;
    logic [SQ_NW-1:0]       r6_rest;
    logic [29:0]            r6_cos30;
    logic                   r6_trig;
    logic                   r6_neg;
    logic signed [SW-1:0]   r6_s [4];
    logic signed [SW-1:0]   r6_e [4];
    t_q15                   r6_tt;

    logic signed [63:0] n_d64;
    logic [63:0]        n_mag;
    logic [CW:0]        n_cmp;

    logic [SN_W-1:0] w_sn;
    logic [SN_W-1:0] w_cos_d;
    logic [SN_W-1:0] w_sn_d;
    t_cw             w_ang;
    t_q15            w_tt_a;
    logic signed [MW-1:0] n_pr0;
    logic signed [MW-1:0] n_pr1;
    t_cw             r7_a0;
    t_cw             r7_a1;
    t_cw             w_y0;
    t_cw             w_y1;
    logic signed [WT_W-1:0] w_q0;
    logic signed [WT_W-1:0] w_q1;
    logic [SIDEW-1:0] w_side_in;
    logic [SIDEW-1:0] w_side;

    logic signed [SW-1:0]   w_ds [4];
    logic signed [SW-1:0]   w_de [4];
    t_q15                   w_dtt;
    logic                   w_dneg;
    logic                   w_dtrig;
    logic signed [WT_W-1:0] n_w0;
    logic signed [WT_W-1:0] n_w1r;
    logic signed [WT_W-1:0] n_w1;

    logic signed [WT_W-1:0] r8_w0;
    logic signed [WT_W-1:0] r8_w1;
    logic signed [SW-1:0]   r8_s [4];
    logic signed [SW-1:0]   r8_e [4];
    logic signed [PRW-1:0]  r9_m0 [4];
    logic signed [PRW-1:0]  r9_m1 [4];
    logic signed [CB-1:0]   n_out [4];
    logic signed [CB-1:0]   r_out [4];

    // configuration
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_THR_IDX) ? {16'b0, r_thr} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (w_wr && paddr[2] == REG_THR_IDX) begin
            r_thr <= pwdata[15:0];
        end
    end

    // pipeline control
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[NTOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NTOT-2:0], i_valid};
        end
    end

    assign w_si = '{i_start_w, i_start_x, i_start_y, i_start_z};
    assign w_ei = '{i_end_w, i_end_x, i_end_y, i_end_z};

    // head: widen, dot product, cosine, radicand
    assign n_d64 = 64'(r3_sum) <<< (2 * UP);
    assign n_mag = n_d64[63] ? 64'(-n_d64) : 64'(n_d64);
    assign n_cmp = (CW+1)'(r4_cos) + (CW+1)'({r_thr, 15'b0});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r1_s[k] <= SW'(w_si[k] >>> (CB - SW));
                r1_e[k] <= SW'(w_ei[k] >>> (CB - SW));
                r2_p[k] <= r1_s[k] * r1_e[k];
                r2_s[k] <= r1_s[k];
                r2_e[k] <= r1_e[k];
                r3_s[k] <= r2_s[k];
                r3_e[k] <= r2_e[k];
                r4_s[k] <= r3_s[k];
                r4_e[k] <= r3_e[k];
                r5_s[k] <= r4_s[k];
                r5_e[k] <= r4_e[k];
                r6_s[k] <= r5_s[k];
                r6_e[k] <= r5_e[k];
            end
            r1_tt    <= (i_blend_time > T_ONE) ? T_ONE : i_blend_time;
            r2_tt    <= r1_tt;
            r3_sum   <= SUMW'(r2_p[0]) + SUMW'(r2_p[1]) + SUMW'(r2_p[2]) + SUMW'(r2_p[3]);
            r3_tt    <= r2_tt;
            r4_cos   <= n_mag[63:30];
            r4_neg   <= n_d64[63];
            r4_tt    <= r3_tt;
            r5_trig  <= n_cmp < (CW+1)'(35'h4000_0000);
            r5_sq    <= r4_cos[29:0] * r4_cos[29:0];
            r5_cos30 <= r4_cos[29:0];
            r5_neg   <= r4_neg;
            r5_tt    <= r4_tt;
            r6_rest  <= SQ_NW'(61'h1000_0000_0000_0000) - SQ_NW'(r5_sq);
            r6_cos30 <= r5_cos30;
            r6_trig  <= r5_trig;
            r6_neg   <= r5_neg;
            r6_tt    <= r5_tt;
        end
    end

    // angle and weights
    qslerp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r6_rest),
        .o_root (w_sn)
    );

    qslerp_dly #(.W(SN_W), .D(L_SQ)) u_dly_cos (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({1'b0, r6_cos30}),
        .o_d   (w_cos_d)
    );

    qslerp_atan u_atan (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cos (w_cos_d),
        .i_sin (w_sn),
        .o_ang (w_ang)
    );

    qslerp_dly #(.W(16), .D(L_SQ + L_AT)) u_dly_tt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r6_tt),
        .o_d   (w_tt_a)
    );

    assign n_pr0 = w_ang * $signed({1'b0, T_ONE - w_tt_a});
    assign n_pr1 = w_ang * $signed({1'b0, w_tt_a});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_a0 <= t_cw'(n_pr0 >>> 15);
            r7_a1 <= t_cw'(n_pr1 >>> 15);
        end
    end

    qslerp_sine u_sine0 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r7_a0),
        .o_sin (w_y0)
    );

    qslerp_sine u_sine1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r7_a1),
        .o_sin (w_y1)
    );

    qslerp_dly #(.W(SN_W), .D(L_AT + 1 + L_SIN)) u_dly_sn (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_sn),
        .o_d   (w_sn_d)
    );

    qslerp_div u_div0 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_y0),
        .i_den (w_sn_d),
        .o_quo (w_q0)
    );

    qslerp_div u_div1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_y1),
        .i_den (w_sn_d),
        .o_quo (w_q1)
    );

    // components and flags ride alongside
    assign w_side_in = {r6_s[0], r6_s[1], r6_s[2], r6_s[3],
                        r6_e[0], r6_e[1], r6_e[2], r6_e[3],
                        r6_tt, r6_neg, r6_trig};

    qslerp_dly #(.W(SIDEW), .D(D_SIDE)) u_dly_side (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_side_in),
        .o_d   (w_side)
    );

    assign {w_ds[0], w_ds[1], w_ds[2], w_ds[3],
            w_de[0], w_de[1], w_de[2], w_de[3],
            w_dtt, w_dneg, w_dtrig} = w_side;

    // tail: select weights, scale, round and saturate
    assign n_w0  = w_dtrig ? w_q0 : WT_W'({T_ONE - w_dtt, 15'b0});
    assign n_w1r = w_dtrig ? w_q1 : WT_W'({w_dtt, 15'b0});
    assign n_w1  = w_dneg ? -n_w1r : n_w1r;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic signed [ACW-1:0] acc;
            logic signed [ACW-1:0] rnd;
            acc = ACW'(r9_m0[k]) + ACW'(r9_m1[k]) + RND;
            rnd = acc >>> RS;
            if (rnd > SAT_HI) begin
                n_out[k] = CB'(SAT_HI);
            end else if (rnd < SAT_LO) begin
                n_out[k] = CB'(SAT_LO);
            end else begin
                n_out[k] = CB'(rnd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_w0 <= n_w0;
            r8_w1 <= n_w1;
            for (int k = 0; k < 4; k++) begin
                r8_s[k]  <= w_ds[k];
                r8_e[k]  <= w_de[k];
                r9_m0[k] <= r8_w0 * r8_s[k];
                r9_m1[k] <= r8_w1 * r8_e[k];
                r_out[k] <= n_out[k];
            end
        end
    end

    assign o_out_w = r_out[0];
    assign o_out_x = r_out[1];
    assign o_out_y = r_out[2];
    assign o_out_z = r_out[3];

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while output held");

    a_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_trig_cos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && (n_cmp < (CW+1)'(35'h4000_0000))) |-> (r4_cos[CW-1:30] == '0))
        else $error("trig path taken with cosine at or above one");

    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[NTOT-2]) |=> o_valid)
        else $error("item lost at output stage");

endmodule

`default_nettype wire

// ----- hdl/qslerp_dly.sv -----
`default_nettype none

module qslerp_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_sh [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    assign o_d = r_sh[D-1];

endmodule

`default_nettype wire

// ----- hdl/qslerp_sqrt.sv -----
`default_nettype none

module qslerp_sqrt import qslerp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [SQ_NW-1:0] i_rad,
    output logic [SN_W-1:0]  o_root
);

    localparam int RW = SQ_NW + 1;

    logic [SQ_NW-1:0] r_n [SQRT_STEPS];
    logic [RW-1:0]    r_r [SQRT_STEPS];
    logic [SQ_NW-1:0] n_n [SQRT_STEPS];
    logic [RW-1:0]    n_r [SQRT_STEPS];

    // one result bit per stage
    always_comb begin
        for (int i = 0; i < SQRT_STEPS; i++) begin
            logic [RW-1:0] cur_n;
            logic [RW-1:0] cur_r;
            logic [RW-1:0] bit_v;
            logic [RW-1:0] trial;
            if (i == 0) begin
                cur_n = RW'(i_rad);
                cur_r = '0;
            end else begin
                cur_n = RW'(r_n[i-1]);
                cur_r = r_r[i-1];
            end
            bit_v = RW'(1) << (2 * (SQRT_STEPS - 1 - i));
            trial = cur_r + bit_v;
            if (cur_n >= trial) begin
                n_n[i] = SQ_NW'(cur_n - trial);
                n_r[i] = (cur_r >> 1) + bit_v;
            end else begin
                n_n[i] = SQ_NW'(cur_n);
                n_r[i] = cur_r >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < SQRT_STEPS; i++) begin
                r_n[i] <= n_n[i];
                r_r[i] <= n_r[i];
            end
        end
    end

    assign o_root = SN_W'(r_r[SQRT_STEPS-1]);

endmodule

`default_nettype wire

// ----- hdl/qslerp_atan.sv -----
`default_nettype none

module qslerp_atan import qslerp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SN_W-1:0] i_cos,
    input  logic [SN_W-1:0] i_sin,
    output t_cw             o_ang
);

    t_cw r_x [CORDIC_STEPS];
    t_cw r_y [CORDIC_STEPS];
    t_cw r_z [CORDIC_STEPS];
    t_cw n_x [CORDIC_STEPS];
    t_cw n_y [CORDIC_STEPS];
    t_cw n_z [CORDIC_STEPS];

    // vectoring: drive y to zero, collect the angle
    always_comb begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t_cw cx;
            t_cw cy;
            t_cw cz;
            t_cw dx;
            t_cw dy;
            t_cw arc;
            if (i == 0) begin
                cx = t_cw'(i_cos);
                cy = t_cw'(i_sin);
                cz = '0;
            end else begin
                cx = r_x[i-1];
                cy = r_y[i-1];
                cz = r_z[i-1];
            end
            dx  = cy >>> i;
            dy  = cx >>> i;
            arc = t_cw'(arc_at(i));
            if (cy > 0) begin
                n_x[i] = cx + dx;
                n_y[i] = cy - dy;
                n_z[i] = cz + arc;
            end else begin
                n_x[i] = cx - dx;
                n_y[i] = cy + dy;
                n_z[i] = cz - arc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
        end
    end

    assign o_ang = r_z[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ----- hdl/qslerp_sine.sv -----
`default_nettype none

module qslerp_sine import qslerp_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_cw  i_ang,
    output t_cw  o_sin
);

    t_cw r_x [CORDIC_STEPS];
    t_cw r_y [CORDIC_STEPS];
    t_cw r_z [CORDIC_STEPS];
    t_cw n_x [CORDIC_STEPS];
    t_cw n_y [CORDIC_STEPS];
    t_cw n_z [CORDIC_STEPS];

    // rotation from a gain-compensated unit vector
    always_comb begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t_cw cx;
            t_cw cy;
            t_cw cz;
            t_cw dx;
            t_cw dy;
            t_cw arc;
            if (i == 0) begin
                cx = t_cw'(CORDIC_GAIN);
                cy = '0;
                cz = i_ang;
            end else begin
                cx = r_x[i-1];
                cy = r_y[i-1];
                cz = r_z[i-1];
            end
            dx  = cy >>> i;
            dy  = cx >>> i;
            arc = t_cw'(arc_at(i));
            if (cz >= 0) begin
                n_x[i] = cx - dx;
                n_y[i] = cy + dy;
                n_z[i] = cz - arc;
            end else begin
                n_x[i] = cx + dx;
                n_y[i] = cy - dy;
                n_z[i] = cz + arc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
        end
    end

    assign o_sin = r_y[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ----- hdl/qslerp_div.sv -----
`default_nettype none

module qslerp_div import qslerp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  t_cw                    i_num,
    input  logic [SN_W-1:0]        i_den,
    output logic signed [WT_W-1:0] o_quo
);

    localparam int DW = CW + 30;
    localparam int EW = SN_W + DIV_QB;

    logic [DW-1:0]     r_rem0;
    logic [SN_W-1:0]   r_den0;
    logic              r_sg0;
    logic [DW-1:0]     r_rem [DIV_QB];
    logic [DIV_QB-1:0] r_quo [DIV_QB];
    logic [SN_W-1:0]   r_den [DIV_QB];
    logic              r_sg  [DIV_QB];
    logic [DW-1:0]     n_rem [DIV_QB];
    logic [DIV_QB-1:0] n_quo [DIV_QB];
    logic [CW-1:0]     n_mag;
    logic signed [WT_W-1:0] n_q;
    logic signed [WT_W-1:0] r_out;

    assign n_mag = i_num[CW-1] ? CW'(-i_num) : CW'(i_num);

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int i = 0; i < DIV_QB; i++) begin
            logic [DW-1:0]     cur_rem;
            logic [DIV_QB-1:0] cur_quo;
            logic [SN_W-1:0]   cur_den;
            logic [EW-1:0]     dsh;
            if (i == 0) begin
                cur_rem = r_rem0;
                cur_quo = '0;
                cur_den = r_den0;
            end else begin
                cur_rem = r_rem[i-1];
                cur_quo = r_quo[i-1];
                cur_den = r_den[i-1];
            end
            dsh = EW'(cur_den) << (DIV_QB - 1 - i);
            if (EW'(cur_rem) >= dsh) begin
                n_rem[i] = cur_rem - DW'(dsh);
                n_quo[i] = {cur_quo[DIV_QB-2:0], 1'b1};
            end else begin
                n_rem[i] = cur_rem;
                n_quo[i] = {cur_quo[DIV_QB-2:0], 1'b0};
            end
        end
    end

    assign n_q = WT_W'(r_quo[DIV_QB-1][WT_W-2:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= {n_mag, 30'b0};
            r_den0 <= i_den;
            r_sg0  <= i_num[CW-1];
            for (int i = 0; i < DIV_QB; i++) begin
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
                r_den[i] <= (i == 0) ? r_den0 : r_den[(i == 0) ? 0 : i-1];
                r_sg[i]  <= (i == 0) ? r_sg0 : r_sg[(i == 0) ? 0 : i-1];
            end
            r_out <= r_sg[DIV_QB-1] ? -n_q : n_q;
        end
    end

    assign o_quo = r_out;

endmodule

`default_nettype wire
